### design/nvpf_pkg.sv
`timescale 1ns / 1ps
// nvpf_pkg: shared types and constants of the NV12 padding formatter.
// No dependencies; used by every module under design/.
package nvpf_pkg;

  localparam int DIM_W   = 13;
  localparam int RUN_W   = 25;
  localparam int PIX_W   = 8;
  localparam int MAX_DIM = 4096;

  localparam logic [PIX_W-1:0] LUMA_FILL   = 8'd0;
  localparam logic [PIX_W-1:0] CHROMA_FILL = 8'd128;

  // register indexes on the configuration port
  localparam logic [1:0] REG_IN_WIDTH   = 2'd0;
  localparam logic [1:0] REG_IN_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_OUT_WIDTH  = 2'd2;
  localparam logic [1:0] REG_OUT_HEIGHT = 2'd3;

  // result kinds
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_FILL = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  // which result of an item is on the output
  typedef enum logic [2:0] {
    PH_DATA   = 3'b001,
    PH_RIGHT  = 3'b010,
    PH_BOTTOM = 3'b100
  } phase_t;

  // source geometry used by the position counters
  typedef struct packed {
    logic [DIM_W-1:0] in_width;
    logic [DIM_W-1:0] in_height;
  } geom_t;

  // values derived from the registers, held in flops
  typedef struct packed {
    logic             ok;
    logic [DIM_W-1:0] right;
    logic [RUN_W-1:0] bot_luma;
    logic [RUN_W-1:0] bot_chroma;
  } drv_t;

  // one accepted byte with its position flags
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             chroma;
    logic             row_end;
    logic             plane_end;
  } item_t;

endpackage

### design/nvpf_cfg.sv
`timescale 1ns / 1ps
// nvpf_cfg: configuration registers and the fill lengths derived from them.
// Depends on nvpf_pkg.
module nvpf_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic [1:0]                wr_index,
  input  logic [nvpf_pkg::DIM_W-1:0] wr_data,
  output nvpf_pkg::geom_t           geom,
  output nvpf_pkg::drv_t            drv
);

  logic [nvpf_pkg::DIM_W-1:0] in_width_r, in_height_r, out_width_r, out_height_r;
  nvpf_pkg::drv_t             drv_r, drv_nxt;

  logic [nvpf_pkg::DIM_W-1:0]   bottom;
  logic [2*nvpf_pkg::DIM_W-1:0] prod_luma, prod_chroma;
  logic                         dims_ok;

  // write one register per beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_width_r   <= '0;
      in_height_r  <= '0;
      out_width_r  <= '0;
      out_height_r <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        nvpf_pkg::REG_IN_WIDTH:   in_width_r   <= wr_data;
        nvpf_pkg::REG_IN_HEIGHT:  in_height_r  <= wr_data;
        nvpf_pkg::REG_OUT_WIDTH:  out_width_r  <= wr_data;
        nvpf_pkg::REG_OUT_HEIGHT: out_height_r <= wr_data;
        default: ;
      endcase
    end
  end

  // check the settings and work out the fill lengths
  always_comb begin
    dims_ok = (in_width_r != '0) && (in_height_r != '0)
              && !(in_width_r[0] | in_height_r[0] | out_width_r[0] | out_height_r[0])
              && (out_width_r >= in_width_r) && (out_height_r >= in_height_r)
              && !((out_width_r == in_width_r) && (out_height_r == in_height_r))
              && (out_width_r  <= nvpf_pkg::DIM_W'(nvpf_pkg::MAX_DIM))
              && (out_height_r <= nvpf_pkg::DIM_W'(nvpf_pkg::MAX_DIM));
    bottom      = out_height_r - in_height_r;
    prod_luma   = bottom * out_width_r;
    prod_chroma = {1'b0, bottom[nvpf_pkg::DIM_W-1:1]} * out_width_r;
    drv_nxt.ok         = dims_ok;
    drv_nxt.right      = out_width_r - in_width_r;
    drv_nxt.bot_luma   = prod_luma[nvpf_pkg::RUN_W-1:0];
    drv_nxt.bot_chroma = prod_chroma[nvpf_pkg::RUN_W-1:0];
  end

  // hold the derived values in flops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drv_r <= '0;
    end else begin
      drv_r <= drv_nxt;
    end
  end

  assign geom.in_width  = in_width_r;
  assign geom.in_height = in_height_r;
  assign drv            = drv_r;

endmodule

### design/nvpf_seq.sv
`timescale 1ns / 1ps
// nvpf_seq: result register that issues the one to three results of a byte.
// Depends on nvpf_pkg.
module nvpf_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       item_valid,
  input  nvpf_pkg::item_t            item,
  input  nvpf_pkg::drv_t             drv,
  output logic                       load,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_kind,
  output logic [nvpf_pkg::PIX_W-1:0] out_value,
  output logic [nvpf_pkg::RUN_W-1:0] out_run_length,
  output logic                       out_frame_last,
  output logic                       out_item_last
);

  logic              v_r, v_nxt;
  nvpf_pkg::item_t   it_r, it_nxt;
  nvpf_pkg::phase_t  ph_r, ph_nxt, ph_next;

  logic                       need_right, need_bottom, more, fire;
  logic [nvpf_pkg::RUN_W-1:0] bot_run;
  logic [nvpf_pkg::PIX_W-1:0] fill;
  nvpf_pkg::kind_t            kind;

  // select the result for the current phase
  always_comb begin
    bot_run     = it_r.chroma ? drv.bot_chroma : drv.bot_luma;
    fill        = it_r.chroma ? nvpf_pkg::CHROMA_FILL : nvpf_pkg::LUMA_FILL;
    need_right  = it_r.row_end && (drv.right != '0);
    need_bottom = it_r.plane_end && (bot_run != '0);
    kind           = nvpf_pkg::KIND_FILL;
    out_value      = fill;
    out_run_length = '0;
    more           = 1'b0;
    ph_next        = nvpf_pkg::PH_DATA;
    unique case (ph_r)
      nvpf_pkg::PH_DATA: begin
        if (!drv.ok) begin
          kind      = nvpf_pkg::KIND_ERR;
          out_value = '0;
        end else begin
          kind           = nvpf_pkg::KIND_DATA;
          out_value      = it_r.pixel;
          out_run_length = nvpf_pkg::RUN_W'(1);
          more           = need_right || need_bottom;
          ph_next        = need_right ? nvpf_pkg::PH_RIGHT : nvpf_pkg::PH_BOTTOM;
        end
      end
      nvpf_pkg::PH_RIGHT: begin
        out_run_length = nvpf_pkg::RUN_W'(drv.right);
        more           = need_bottom;
        ph_next        = nvpf_pkg::PH_BOTTOM;
      end
      nvpf_pkg::PH_BOTTOM: begin
        out_run_length = bot_run;
      end
      default: ;
    endcase
    out_kind       = kind;
    out_item_last  = !more;
    out_frame_last = !more && it_r.plane_end && it_r.chroma;
  end

  // advance the phase, or take the next byte once the last result leaves
  always_comb begin
    fire   = v_r && !out_stall;
    load   = item_valid && (!v_r || (fire && !more));
    v_nxt  = v_r;
    it_nxt = it_r;
    ph_nxt = ph_r;
    if (load) begin
      v_nxt  = 1'b1;
      it_nxt = item;
      ph_nxt = nvpf_pkg::PH_DATA;
    end else if (fire) begin
      if (more) begin
        ph_nxt = ph_next;
      end else begin
        v_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= 1'b0;
      ph_r <= nvpf_pkg::PH_DATA;
    end else begin
      v_r  <= v_nxt;
      ph_r <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    it_r <= it_nxt;
  end

  assign out_valid = v_r;

endmodule

### design/nv12_pad_formatter.sv
`timescale 1ns / 1ps
// nv12_pad_formatter: NV12 right/bottom padding stage, top level.
// Depends on nvpf_pkg, nvpf_cfg and nvpf_seq.
//
//   channel | handshake           | payload
//   --------+---------------------+---------------------------------------------
//   in      | in_valid/in_stall   | in_pixel
//   out     | out_valid/out_stall | out_kind, out_value, out_run_length,
//           |                     | out_frame_last, out_item_last
//   cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data (cfg_ready always high)
//
// One byte a cycle enters while in_stall is low; a byte gives one result in most
// places and two or three at a row or plane end, one result per cycle from the
// result register while out_stall is low. A byte passes the input flop, then the
// result flop. The position counters move at accept. Reset is synchronous, active
// low, and clears registers, counters and both stages. out_stall back-pressures
// the result register, then the input flop, then in_stall.
module nv12_pad_formatter (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [nvpf_pkg::PIX_W-1:0] in_pixel,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_kind,
  output logic [nvpf_pkg::PIX_W-1:0] out_value,
  output logic [nvpf_pkg::RUN_W-1:0] out_run_length,
  output logic                       out_frame_last,
  output logic                       out_item_last,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [nvpf_pkg::DIM_W-1:0] cfg_data
);

  nvpf_pkg::geom_t geom;
  nvpf_pkg::drv_t  drv;

  logic                       s1_v_r, s1_v_nxt;
  nvpf_pkg::item_t            s1_r, s1_nxt;
  logic [nvpf_pkg::DIM_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic                       chroma_r, chroma_nxt;

  logic                       accept, load;
  logic [nvpf_pkg::DIM_W:0]   col_inc, row_inc;
  logic [nvpf_pkg::DIM_W-1:0] plane_rows;
  logic                       row_end, plane_end;

  assign cfg_ready = 1'b1;

  nvpf_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .geom     (geom),
    .drv      (drv)
  );

  // locate the byte in the frame
  always_comb begin
    col_inc    = {1'b0, col_r} + 1'b1;
    row_inc    = {1'b0, row_r} + 1'b1;
    plane_rows = chroma_r ? {1'b0, geom.in_height[nvpf_pkg::DIM_W-1:1]} : geom.in_height;
    row_end    = col_inc >= {1'b0, geom.in_width};
    plane_end  = row_end && (row_inc >= {1'b0, plane_rows});
  end

  // take a beat when the input flop is free or moves on this cycle
  assign in_stall = s1_v_r && !load;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_v_nxt   = s1_v_r;
    s1_nxt     = s1_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    chroma_nxt = chroma_r;
    if (load) begin
      s1_v_nxt = 1'b0;
    end
    if (accept) begin
      s1_v_nxt         = 1'b1;
      s1_nxt.pixel     = in_pixel;
      s1_nxt.chroma    = chroma_r;
      s1_nxt.row_end   = row_end;
      s1_nxt.plane_end = plane_end;
      if (!row_end) begin
        col_nxt = col_inc[nvpf_pkg::DIM_W-1:0];
      end else begin
        col_nxt = '0;
        if (!plane_end) begin
          row_nxt = row_inc[nvpf_pkg::DIM_W-1:0];
        end else begin
          row_nxt    = '0;
          chroma_nxt = !chroma_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      col_r    <= '0;
      row_r    <= '0;
      chroma_r <= 1'b0;
    end else begin
      s1_v_r   <= s1_v_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      chroma_r <= chroma_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

  nvpf_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (s1_v_r),
    .item           (s1_r),
    .drv            (drv),
    .load           (load),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_value      (out_value),
    .out_run_length (out_run_length),
    .out_frame_last (out_frame_last),
    .out_item_last  (out_item_last)
  );

endmodule
